### rtl/core/assert_macros.svh
// Concurrent assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// cond holds at every clock edge outside reset
`define ASSERT_ALWAYS(lbl, clk, rst, cond) \
   lbl: assert property (@(posedge clk) disable iff (rst) (cond)) \
      else $error("assertion failed");

// cons holds in the same cycle as ante
`define ASSERT_IMPLIES(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// cons holds in the cycle after ante
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`else

`define ASSERT_ALWAYS(lbl, clk, rst, cond)
`define ASSERT_IMPLIES(lbl, clk, rst, ante, cons)
`define ASSERT_NEXT(lbl, clk, rst, ante, cons)

`endif

`endif

### rtl/core/bpa_pkg.sv
package bpa_pkg;

   localparam int NumPagesDefault = 32768;
   localparam int WordBits        = 32;
   localparam int BitSelW         = 5;
   localparam int MapWordsDefault = (NumPagesDefault + WordBits - 1) / WordBits;
   localparam int CountW          = 16;
   localparam int PageW           = 15;
   localparam int SpanW           = CountW + 1;
   localparam int SpanWordW       = SpanW - BitSelW;
   localparam int PopW            = BitSelW + 1;

   localparam logic [WordBits-1:0] FullWord = '1;

   typedef enum logic [1:0] {
      OP_ALLOC   = 2'd0,
      OP_FREE    = 2'd1,
      OP_RELEASE = 2'd2,
      OP_RESERVE = 2'd3
   } opcode_type;

   // what the word unit is asked to do with one map word
   typedef struct packed {
      logic               alloc;
      logic               set_bits;
      logic [BitSelW-1:0] lo;
      logic [BitSelW-1:0] hi;
   } word_ctl_type;

   typedef struct packed {
      logic [WordBits-1:0] new_word;
      logic [WordBits-1:0] grant_mask;
      logic [BitSelW-1:0]  grant_bit;
      logic [PopW-1:0]     changed;
      logic                full;
   } word_res_type;

endpackage

### rtl/core/bpa_ram.sv
module bpa_ram #(
   parameter int Width = bpa_pkg::WordBits,
   parameter int Depth = bpa_pkg::MapWordsDefault
) (
   input  logic                                   clock,
   input  logic                                   we,
   input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] waddr,
   input  logic [Width-1:0]                       wdata,
   input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] raddr,
   output logic [Width-1:0]                       rdata
);

   logic [Width-1:0] mem [Depth];
   logic [Width-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

### rtl/core/bpa_word_unit.sv
module bpa_word_unit (
   input  logic [bpa_pkg::WordBits-1:0] data,
   input  bpa_pkg::word_ctl_type        ctl,
   output bpa_pkg::word_res_type        res
);

   import bpa_pkg::*;

   logic [WordBits-1:0] range_mask;
   logic [WordBits-1:0] grant_mask;
   logic [WordBits-1:0] region_word;
   logic [WordBits-1:0] new_word;
   logic [BitSelW-1:0]  grant_bit;

   // lowest clear bit as a one-hot, then encode it
   assign grant_mask = ~data & (data + WordBits'(1));

   always_comb begin
      grant_bit = '0;
      for (int i = 0; i < WordBits; i++) begin
         if (grant_mask[i]) begin
            grant_bit = grant_bit | BitSelW'(i);
         end
      end
   end

   assign range_mask  = (FullWord << ctl.lo) & (FullWord >> (BitSelW'(WordBits - 1) - ctl.hi));
   assign region_word = ctl.set_bits ? (data | range_mask) : (data & ~range_mask);
   assign new_word    = ctl.alloc ? (data | grant_mask) : region_word;

   assign res.new_word   = new_word;
   assign res.grant_mask = grant_mask;
   assign res.grant_bit  = grant_bit;
   assign res.changed    = PopW'($countones(data ^ new_word));
   assign res.full       = (data == FullWord);

endmodule

### rtl/core/bitmap_page_allocator_top.sv
// First-fit page allocator over a one-bit-per-page used map held in a single
// RAM of 32-bit words, with a running used-page count. An item is one of
// allocate, free page, release region or reserve region, and yields exactly
// one result with status, granted page, used count and free count, unless a
// write of the total comes before that result is loaded. One word unit reads,
// updates and writes back one map word at a time (registered RAM read, then
// modify and write), so an item visits map words one after another: allocate
// walks words from page zero up to the first word with a clear bit, a region
// touches every word it spans, and free touches one word. An allocate that
// finds the count full, or a region that lies wholly at or above the total,
// visits no map word. After reset and after every write of the total, the map
// is refilled with ones at one word per cycle, and no item is taken meanwhile.
// A new item may be taken while the previous result still waits on the output
// register.
module bitmap_page_allocator_top #(
   parameter int NUM_PAGES = bpa_pkg::NumPagesDefault
) (
   input  logic        clock,
   input  logic        reset,
   // req_tdata: first_page [14:0], block_count [30:15], zero [31]
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,
   // req_tuser: opcode [1:0]
   input  logic [1:0]  req_tuser,
   // rsp_tdata: block_index [14:0], used_count [30:15], free_count [46:31], zero [47]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata,
   // rsp_tuser: status [0]
   output logic [0:0]  rsp_tuser,
   input  logic        csr_we,
   input  logic [15:0] csr_wdata
);

   import bpa_pkg::*;

   localparam int MapWords = (NUM_PAGES + WordBits - 1) / WordBits;
   localparam int WordAw   = (MapWords > 1) ? $clog2(MapWords) : 1;

   typedef enum logic [2:0] {
      S_FILL,
      S_IDLE,
      S_READ,
      S_EXEC,
      S_DONE
   } state_type;

   state_type            state_ff;
   logic [WordAw-1:0]    fill_ff;
   logic [CountW-1:0]    eff_ff;
   logic [CountW-1:0]    used_ff;
   opcode_type           op_ff;
   logic [SpanWordW-1:0] word_ff;
   logic [SpanWordW-1:0] last_ff;
   logic [BitSelW-1:0]   lo_ff;
   logic [BitSelW-1:0]   hi_ff;
   logic                 status_ff;
   logic [PageW-1:0]     index_ff;
   logic                 rsp_tvalid_ff;
   logic [47:0]          rsp_tdata_ff;
   logic [0:0]           rsp_tuser_ff;

   // accept-time decode
   opcode_type        req_op;
   logic [PageW-1:0]  req_start;
   logic [SpanW-1:0]  req_count;
   logic [SpanW-1:0]  span_end;
   logic [SpanW-1:0]  clip_end;
   logic [SpanW-1:0]  last_page;
   logic              span_empty;
   logic              req_take;
   logic [CountW-1:0] cfg_eff;

   // word unit and RAM
   word_ctl_type        wctl;
   word_res_type        wres;
   logic [WordBits-1:0] ram_rdata;
   logic                ram_we;
   logic [WordAw-1:0]   ram_waddr;
   logic [WordBits-1:0] ram_wdata;
   logic                at_last;
   logic                rsp_free;
   logic                rsp_load;

   assign req_op     = opcode_type'(req_tuser);
   assign req_start  = req_tdata[PageW-1:0];
   assign req_count  = (req_op == OP_FREE) ? SpanW'(1) : SpanW'(req_tdata[30:15]);
   assign span_end   = SpanW'(req_start) + req_count;
   assign clip_end   = (span_end > SpanW'(eff_ff)) ? SpanW'(eff_ff) : span_end;
   assign span_empty = (clip_end <= SpanW'(req_start));
   assign last_page  = clip_end - SpanW'(1);
   assign req_tready = (state_ff == S_IDLE);
   assign req_take   = req_tvalid && req_tready;

   assign cfg_eff = (int'(csr_wdata) > NUM_PAGES) ? CountW'(NUM_PAGES) : csr_wdata;

   assign at_last  = (word_ff == last_ff);
   assign rsp_free = !rsp_tvalid_ff || rsp_tready;
   assign rsp_load = (state_ff == S_DONE) && rsp_free && !csr_we;

   assign wctl.alloc    = (op_ff == OP_ALLOC);
   assign wctl.set_bits = (op_ff == OP_RESERVE);
   assign wctl.lo       = lo_ff;
   assign wctl.hi       = at_last ? hi_ff : BitSelW'(WordBits - 1);

   bpa_word_unit u_word (
      .data (ram_rdata),
      .ctl  (wctl),
      .res  (wres)
   );

   always_comb begin
      ram_we    = 1'b0;
      ram_waddr = WordAw'(word_ff);
      ram_wdata = wres.new_word;
      if (state_ff == S_FILL) begin
         ram_we    = 1'b1;
         ram_waddr = fill_ff;
         ram_wdata = FullWord;
      end else if (state_ff == S_EXEC) begin
         ram_we = !(wctl.alloc && wres.full);
      end
   end

   bpa_ram #(
      .Width (WordBits),
      .Depth (MapWords)
   ) u_map (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .raddr (WordAw'(word_ff)),
      .rdata (ram_rdata)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_FILL;
         fill_ff       <= '0;
         eff_ff        <= '0;
         used_ff       <= '0;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         if (rsp_load) begin
            rsp_tvalid_ff <= 1'b1;
         end else if (rsp_tvalid_ff && rsp_tready) begin
            rsp_tvalid_ff <= 1'b0;
         end
         // a new total refills the map with every page used
         if (csr_we) begin
            eff_ff   <= cfg_eff;
            used_ff  <= cfg_eff;
            fill_ff  <= '0;
            state_ff <= S_FILL;
         end else begin
            unique case (state_ff)
               S_FILL: begin
                  fill_ff <= fill_ff + WordAw'(1);
                  if (fill_ff == WordAw'(MapWords - 1)) begin
                     state_ff <= S_IDLE;
                  end
               end
               S_IDLE: begin
                  if (req_take) begin
                     op_ff     <= req_op;
                     status_ff <= 1'b0;
                     index_ff  <= '0;
                     if (req_op == OP_ALLOC) begin
                        word_ff <= '0;
                        last_ff <= '0;
                        lo_ff   <= '0;
                        hi_ff   <= '0;
                        if (used_ff >= eff_ff) begin
                           status_ff <= 1'b1;
                           state_ff  <= S_DONE;
                        end else begin
                           state_ff <= S_READ;
                        end
                     end else begin
                        word_ff <= SpanWordW'(req_start >> BitSelW);
                        last_ff <= last_page[SpanW-1:BitSelW];
                        lo_ff   <= req_start[BitSelW-1:0];
                        hi_ff   <= last_page[BitSelW-1:0];
                        state_ff <= span_empty ? S_DONE : S_READ;
                     end
                  end
               end
               S_READ: begin
                  state_ff <= S_EXEC;
               end
               S_EXEC: begin
                  if (wctl.alloc) begin
                     if (wres.full) begin
                        word_ff  <= word_ff + SpanWordW'(1);
                        state_ff <= S_READ;
                     end else begin
                        used_ff  <= used_ff + CountW'(1);
                        index_ff <= PageW'({word_ff, wres.grant_bit});
                        state_ff <= S_DONE;
                     end
                  end else begin
                     if (wctl.set_bits) begin
                        used_ff <= used_ff + CountW'(wres.changed);
                     end else begin
                        used_ff <= used_ff - CountW'(wres.changed);
                     end
                     // only the first word starts mid-word
                     lo_ff <= '0;
                     if (at_last) begin
                        state_ff <= S_DONE;
                     end else begin
                        word_ff  <= word_ff + SpanWordW'(1);
                        state_ff <= S_READ;
                     end
                  end
               end
               S_DONE: begin
                  if (rsp_free) begin
                     rsp_tdata_ff <= {1'b0, eff_ff - used_ff, used_ff, index_ff};
                     rsp_tuser_ff <= status_ff;
                     state_ff     <= S_IDLE;
                  end
               end
               default: begin
                  state_ff <= S_FILL;
                  fill_ff  <= '0;
               end
            endcase
         end
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;
   assign rsp_tuser  = rsp_tuser_ff;

`include "assert_macros.svh"

   `ASSERT_ALWAYS(a_used_within_total, clock, reset, used_ff <= eff_ff)
   `ASSERT_NEXT(a_cfg_refill, clock, reset, csr_we, state_ff == S_FILL && fill_ff == '0)
   `ASSERT_IMPLIES(a_grant_onehot, clock, reset, state_ff == S_EXEC && wctl.alloc && !wres.full, $onehot(wres.grant_mask))
   `ASSERT_IMPLIES(a_region_in_span, clock, reset, state_ff == S_EXEC && !wctl.alloc, word_ff <= last_ff)

endmodule

### test/tb_top.sv
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import bpa_pkg::*;

   localparam int NumPages = NumPagesDefault;
   localparam int MapWords = MapWordsDefault;
   localparam int CycleLimit = 4000000;
   localparam int ReportLimit = 10;
   localparam int PhaseCount = 10;
   localparam int PhaseItems = 50;
   localparam int DirectedRows = 27;

   typedef struct packed {
      logic        status;
      logic [14:0] index;
      logic [15:0] used_count;
      logic [15:0] free_count;
   } page_result_type;

   typedef enum logic {
      ROW_ITEM,
      ROW_TOTAL
   } row_kind_type;

   // ROW_TOTAL rows carry the page count to write in the count field
   typedef struct packed {
      row_kind_type    kind;
      opcode_type      op;
      logic [14:0]     start;
      logic [15:0]     count;
      logic            typed;
      page_result_type want;
   } plan_row_type;

   logic        clock = 1'b0;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [31:0] req_tdata;
   logic [1:0]  req_tuser;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [47:0] rsp_tdata;
   logic [0:0]  rsp_tuser;
   logic        csr_we;
   logic [15:0] csr_wdata;

   // shadow copy of the allocator state
   bit [31:0]   shadow_map [MapWords];
   int unsigned page_limit;
   int unsigned pages_in_use;
   int unsigned granted_pages [$];

   page_result_type pending_results [$];

   bit no_gaps = 1'b0;
   int cycle_count = 0;
   int mismatch_count = 0;
   int items_sent = 0;
   int totals_written = 0;
   int grants = 0;
   int refusals = 0;

   plan_row_type directed_plan [DirectedRows] = '{
      '{ROW_ITEM,  OP_ALLOC,   15'd0,     16'd0,     1'b1, '{1'b1, 15'd0, 16'd0, 16'd0}},
      '{ROW_ITEM,  OP_RESERVE, 15'd0,     16'd100,   1'b1, '{1'b0, 15'd0, 16'd0, 16'd0}},
      '{ROW_TOTAL, OP_ALLOC,   15'd0,     16'd40,    1'b0, '0},
      '{ROW_ITEM,  OP_ALLOC,   15'd0,     16'd0,     1'b1, '{1'b1, 15'd0, 16'd40, 16'd0}},
      '{ROW_ITEM,  OP_FREE,    15'd39,    16'd0,     1'b1, '{1'b0, 15'd0, 16'd39, 16'd1}},
      '{ROW_ITEM,  OP_FREE,    15'd39,    16'd0,     1'b1, '{1'b0, 15'd0, 16'd39, 16'd1}},
      '{ROW_ITEM,  OP_FREE,    15'd40,    16'd0,     1'b1, '{1'b0, 15'd0, 16'd39, 16'd1}},
      '{ROW_ITEM,  OP_ALLOC,   15'd0,     16'd0,     1'b1, '{1'b0, 15'd39, 16'd40, 16'd0}},
      '{ROW_ITEM,  OP_RELEASE, 15'd0,     16'd0,     1'b1, '{1'b0, 15'd0, 16'd40, 16'd0}},
      '{ROW_ITEM,  OP_RELEASE, 15'd30,    16'd65535, 1'b1, '{1'b0, 15'd0, 16'd30, 16'd10}},
      '{ROW_ITEM,  OP_ALLOC,   15'd0,     16'd0,     1'b0, '0},
      '{ROW_ITEM,  OP_RESERVE, 15'd28,    16'd5,     1'b0, '0},
      '{ROW_ITEM,  OP_RELEASE, 15'd0,     16'd40,    1'b1, '{1'b0, 15'd0, 16'd0, 16'd40}},
      '{ROW_ITEM,  OP_ALLOC,   15'd0,     16'd0,     1'b1, '{1'b0, 15'd0, 16'd1, 16'd39}},
      '{ROW_ITEM,  OP_FREE,    15'd32767, 16'd0,     1'b1, '{1'b0, 15'd0, 16'd1, 16'd39}},
      '{ROW_ITEM,  OP_RESERVE, 15'd32767, 16'd65535, 1'b1, '{1'b0, 15'd0, 16'd1, 16'd39}},
      '{ROW_ITEM,  OP_RESERVE, 15'd0,     16'd65535, 1'b1, '{1'b0, 15'd0, 16'd40, 16'd0}},
      '{ROW_TOTAL, OP_ALLOC,   15'd0,     16'd65535, 1'b0, '0},
      '{ROW_ITEM,  OP_ALLOC,   15'd0,     16'd0,     1'b1, '{1'b1, 15'd0, 16'd32768, 16'd0}},
      '{ROW_ITEM,  OP_RELEASE, 15'd32767, 16'd1,     1'b1, '{1'b0, 15'd0, 16'd32767, 16'd1}},
      '{ROW_ITEM,  OP_ALLOC,   15'd0,     16'd0,     1'b1, '{1'b0, 15'd32767, 16'd32768, 16'd0}},
      '{ROW_ITEM,  OP_RELEASE, 15'd0,     16'd32768, 1'b1, '{1'b0, 15'd0, 16'd0, 16'd32768}},
      '{ROW_ITEM,  OP_ALLOC,   15'd0,     16'd0,     1'b0, '0},
      '{ROW_ITEM,  OP_FREE,    15'd0,     16'd0,     1'b0, '0},
      '{ROW_TOTAL, OP_ALLOC,   15'd0,     16'd1,     1'b0, '0},
      '{ROW_ITEM,  OP_FREE,    15'd0,     16'd0,     1'b1, '{1'b0, 15'd0, 16'd0, 16'd1}},
      '{ROW_ITEM,  OP_ALLOC,   15'd0,     16'd0,     1'b1, '{1'b0, 15'd0, 16'd1, 16'd0}}
   };

   bitmap_page_allocator_top dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata)
   );

   always #10ns clock = ~clock;

   function automatic void set_page_total(input logic [15:0] value, input bit from_reset);
      page_limit = (value > NumPages) ? NumPages : value;
      foreach (shadow_map[w]) shadow_map[w] = FullWord;
      pages_in_use = from_reset ? 0 : page_limit;
      granted_pages.delete();
   endfunction

   function automatic void mark_region(input int unsigned first, input int unsigned len,
                                       input bit set_used);
      int unsigned p;
      for (int unsigned i = 0; i < len; i++) begin
         p = first + i;
         if (p >= page_limit) break;
         if (shadow_map[p / WordBits][p % WordBits] != set_used) begin
            shadow_map[p / WordBits][p % WordBits] = set_used;
            if (set_used) pages_in_use++;
            else pages_in_use--;
         end
      end
   endfunction

   function automatic void predict_page_op(input opcode_type op, input logic [14:0] start,
                                           input logic [15:0] count,
                                           output page_result_type res);
      int unsigned words;
      int unsigned p;
      bit found;
      res = '0;
      found = 1'b0;
      case (op)
         OP_ALLOC: begin
            if (pages_in_use < page_limit) begin
               words = (page_limit + WordBits - 1) / WordBits;
               for (int unsigned w = 0; w < words && !found; w++) begin
                  if (shadow_map[w] != FullWord) begin
                     for (int b = 0; b < WordBits && !found; b++) begin
                        p = w * WordBits + b;
                        if (p < page_limit && !shadow_map[w][b]) begin
                           found = 1'b1;
                           shadow_map[w][b] = 1'b1;
                           pages_in_use++;
                           res.index = p[14:0];
                           granted_pages.push_back(p);
                        end
                     end
                  end
               end
            end
            if (found) grants++;
            else begin
               res.status = 1'b1;
               refusals++;
            end
         end
         OP_FREE: begin
            if (start < page_limit && shadow_map[start / WordBits][start % WordBits]) begin
               shadow_map[start / WordBits][start % WordBits] = 1'b0;
               pages_in_use--;
            end
         end
         OP_RELEASE: mark_region(start, count, 1'b0);
         default: mark_region(start, count, 1'b1);
      endcase
      res.used_count = pages_in_use[15:0];
      res.free_count = 16'(page_limit - pages_in_use);
   endfunction

   // mostly pages near the bottom of the map, so big totals keep the scans short
   function automatic void pick_page_op(output opcode_type op, output logic [14:0] start,
                                        output logic [15:0] count);
      int unsigned span;
      int unsigned near;
      int unsigned roll;
      int unsigned k;
      span = (page_limit == 0) ? 1 : page_limit;
      near = (span > 256) ? 256 : span;
      roll = $urandom_range(0, 99);
      if (roll < 12) start = 15'($urandom_range(0, 32767));
      else if (roll < 20) start = 15'(span - 1 - $urandom_range(0, near - 1));
      else start = 15'($urandom_range(0, near - 1));
      roll = $urandom_range(0, 99);
      if (roll < 75) count = 16'($urandom_range(0, 40));
      else if (roll < 90) count = 16'($urandom_range(0, (2 * span > 65535) ? 65535 : 2 * span));
      else count = 16'($urandom_range(0, 65535));
      roll = $urandom_range(0, 99);
      if (roll < 40) op = OP_ALLOC;
      else if (roll < 65) begin
         op = OP_FREE;
         // hand back a page granted earlier
         if (granted_pages.size() != 0 && $urandom_range(0, 1) == 1) begin
            k = $urandom_range(0, granted_pages.size() - 1);
            start = 15'(granted_pages[k]);
            granted_pages.delete(k);
         end
      end
      else if (roll < 82) op = OP_RELEASE;
      else op = OP_RESERVE;
   endfunction

   task automatic send_item(input opcode_type op, input logic [14:0] start,
                            input logic [15:0] count, input bit typed,
                            input page_result_type typed_result);
      page_result_type res;
      if (!no_gaps) begin
         while ($urandom_range(0, 99) < 21) begin
            req_tvalid <= 1'b0;
            @(negedge clock);
         end
      end
      req_tvalid <= 1'b1;
      req_tdata <= {1'b0, count, start};
      req_tuser <= op;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      predict_page_op(op, start, count, res);
      pending_results.push_back(typed ? typed_result : res);
      items_sent++;
      @(negedge clock);
   endtask

   task automatic write_total(input logic [15:0] value);
      req_tvalid <= 1'b0;
      while (pending_results.size() != 0) @(negedge clock);
      csr_we <= 1'b1;
      csr_wdata <= value;
      @(negedge clock);
      csr_we <= 1'b0;
      set_page_total(value, 1'b0);
      totals_written++;
   endtask

   always @(negedge clock) begin
      rsp_tready <= no_gaps || ($urandom_range(0, 99) >= 21);
   end

   always @(posedge clock) begin
      page_result_type got;
      page_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.status = rsp_tuser[0];
         got.index = rsp_tdata[14:0];
         got.used_count = rsp_tdata[30:15];
         got.free_count = rsp_tdata[46:31];
         if (pending_results.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= ReportLimit)
               $display("unexpected result: status %0d index %0d used %0d free %0d",
                        got.status, got.index, got.used_count, got.free_count);
         end
         else begin
            want = pending_results.pop_front();
            if (got.status !== want.status || got.index !== want.index ||
                got.used_count !== want.used_count || got.free_count !== want.free_count) begin
               mismatch_count++;
               if (mismatch_count <= ReportLimit)
                  $display({"mismatch: expected status %0d index %0d used %0d free %0d, ",
                            "got status %0d index %0d used %0d free %0d"},
                           want.status, want.index, want.used_count, want.free_count,
                           got.status, got.index, got.used_count, got.free_count);
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CycleLimit) begin
         $display("timeout after %0d cycles, %0d results outstanding",
                  cycle_count, pending_results.size());
         $display("tb_top: FAIL");
         $finish;
      end
   end

   initial begin
      opcode_type  op;
      logic [14:0] start;
      logic [15:0] count;
      logic [15:0] phase_totals [PhaseCount];
      phase_totals = '{16'd1, 16'd31, 16'd32, 16'd33, 16'd64, 16'd100, 16'd65535,
                       16'd200, 16'd0, 16'd32768};
      phase_totals[8] = 16'($urandom_range(2, 700));
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      req_tuser = OP_ALLOC;
      rsp_tready = 1'b0;
      csr_we = 1'b0;
      csr_wdata = '0;
      set_page_total(16'd0, 1'b1);
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (directed_plan[i]) begin
         if (directed_plan[i].kind == ROW_TOTAL) write_total(directed_plan[i].count);
         else send_item(directed_plan[i].op, directed_plan[i].start, directed_plan[i].count,
                        directed_plan[i].typed, directed_plan[i].want);
      end

      for (int ph = 0; ph < PhaseCount; ph++) begin
         // run two phases back to back with no idle cycles on either side
         no_gaps = (ph == 4 || ph == 5);
         write_total(phase_totals[ph]);
         repeat (PhaseItems) begin
            pick_page_op(op, start, count);
            send_item(op, start, count, 1'b0, '0);
         end
      end

      req_tvalid <= 1'b0;
      no_gaps = 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);

      $display("run covered %0d requests under %0d page totals: %0d pages granted, %0d refused",
               items_sent, totals_written, grants, refusals);
      $display("%0d mismatches in %0d cycles", mismatch_count, cycle_count);
      if (mismatch_count == 0 && pending_results.size() == 0) begin
         $display("tb_top: PASS");
      end
      else begin
         $display("tb_top: FAIL");
      end
      $finish;
   end

endmodule
